### design/iir_pkg.sv
// shared types, constants and sizes for the direct-form i iir filter
// no dependencies; used by iir_ctrl, iir_datapath and iir_direct_form_filter
`default_nettype none

package iir_pkg;

    localparam int TAPS    = 11;
    localparam int HIST_N  = TAPS - 1;
    localparam int TAP_W   = $clog2(TAPS);
    localparam int HIST_IW = (HIST_N > 1) ? $clog2(HIST_N) : 1;
    localparam int CNT_W   = (TAP_W > 4) ? TAP_W : 4;

    localparam int COEF_W  = 24;
    localparam int SAMP_W  = 16;
    localparam int PROD_W  = COEF_W + SAMP_W;
    localparam int ACC_W   = PROD_W + $clog2(2 * TAPS) + 1;
    localparam int QUO_W   = 16;
    localparam int DIV_W   = COEF_W + QUO_W;

    localparam logic [1:0] ACT_LOAD_B = 2'd0;
    localparam logic [1:0] ACT_LOAD_A = 2'd1;
    localparam logic [1:0] ACT_FILTER = 2'd2;

    localparam logic [QUO_W-1:0] POS_LIMIT = 16'h7fff;
    localparam logic [QUO_W-1:0] NEG_LIMIT = 16'h8000;

    typedef struct packed {
        logic [1:0]               action;
        logic [3:0]               coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [SAMP_W-1:0] sample_in;
        logic                     frame_start;
    } iir_in_t;

    typedef struct packed {
        logic signed [SAMP_W-1:0] sample_out;
        logic                     saturated;
        logic                     divide_fault;
    } iir_out_t;

    typedef struct packed {
        logic             load_b;
        logic             load_a;
        logic             start;
        logic             mac_issue;
        logic [TAP_W-1:0] tap;
        logic             check;
        logic             div_step;
        logic             finish;
    } iir_cmd_t;

endpackage

`default_nettype wire

### design/iir_ctrl.sv
// sequencer for the iir filter: input/output handshakes, tap walk, divide steps
// depends on iir_pkg; drives iir_datapath through iir_cmd_t
`default_nettype none

module iir_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire iir_pkg::iir_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output iir_pkg::iir_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [iir_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      in_beat;
    logic                      out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd           = '0;
        cmd.load_b    = in_beat && (s_data.action == iir_pkg::ACT_LOAD_B);
        cmd.load_a    = in_beat && (s_data.action == iir_pkg::ACT_LOAD_A);
        cmd.start     = in_beat && (s_data.action == iir_pkg::ACT_FILTER);
        cmd.mac_issue = (state_reg == ST_MAC);
        cmd.tap       = cnt_reg[iir_pkg::TAP_W-1:0];
        cmd.check     = (state_reg == ST_CHECK);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.finish    = (state_reg == ST_DONE) && out_free;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = ST_MAC;
                    cnt_next   = '0;
                end
            end
            ST_MAC: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == iir_pkg::CNT_W'(iir_pkg::TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == iir_pkg::CNT_W'(iir_pkg::QUO_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/iir_datapath.sv
// iir datapath: coefficient banks, histories, two multipliers, accumulator,
// restoring divider and result register; depends on iir_pkg
`default_nettype none

module iir_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire iir_pkg::iir_in_t  s_data,
    input  wire iir_pkg::iir_cmd_t cmd,
    output iir_pkg::iir_out_t      m_data
);

    localparam int TAPS    = iir_pkg::TAPS;
    localparam int HIST_N  = iir_pkg::HIST_N;
    localparam int HIST_IW = iir_pkg::HIST_IW;
    localparam int TAP_W   = iir_pkg::TAP_W;
    localparam int COEF_W  = iir_pkg::COEF_W;
    localparam int SAMP_W  = iir_pkg::SAMP_W;
    localparam int PROD_W  = iir_pkg::PROD_W;
    localparam int ACC_W   = iir_pkg::ACC_W;
    localparam int QUO_W   = iir_pkg::QUO_W;
    localparam int DIV_W   = iir_pkg::DIV_W;

    logic signed [COEF_W-1:0] fwd_reg [TAPS];
    logic signed [COEF_W-1:0] fb_reg  [TAPS];
    logic signed [SAMP_W-1:0] in_hist_reg  [HIST_N];
    logic signed [SAMP_W-1:0] out_hist_reg [HIST_N];
    logic [TAP_W-1:0]         fill_reg;

    logic signed [SAMP_W-1:0] x_reg;
    logic signed [PROD_W-1:0] prod_b_reg, prod_b_next;
    logic signed [PROD_W-1:0] prod_a_reg, prod_a_next;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         dv_reg;
    logic [QUO_W-1:0]         q_reg;
    logic                     neg_reg, ovf_reg, fault_reg;
    iir_pkg::iir_out_t        result_reg;

    logic [HIST_IW-1:0]       hidx;
    logic signed [COEF_W-1:0] b_sel, a_sel;
    logic signed [SAMP_W-1:0] x_sel, y_sel;
    logic                     tap_used;

    logic [ACC_W-1:0]         acc_abs;
    logic [COEF_W-1:0]        d_abs;
    logic [DIV_W-1:0]         d_top;
    logic                     ovf_now;
    logic [SAMP_W-1:0]        y_val;
    logic                     sat_val;

    assign m_data = result_reg;

    // operand select for the current tap
    always_comb begin
        hidx     = HIST_IW'(cmd.tap - 1'b1);
        b_sel    = fwd_reg[cmd.tap];
        a_sel    = fb_reg[cmd.tap];
        x_sel    = (cmd.tap == '0) ? x_reg : in_hist_reg[hidx];
        y_sel    = out_hist_reg[hidx];
        tap_used = (cmd.tap <= fill_reg);
        prod_b_next = '0;
        prod_a_next = '0;
        if (tap_used) begin
            prod_b_next = b_sel * x_sel;
            if (cmd.tap != '0) begin
                prod_a_next = a_sel * y_sel;
            end
        end
    end

    // divider setup and overflow test
    always_comb begin
        acc_abs = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        d_abs   = fb_reg[0][COEF_W-1] ? (~fb_reg[0] + 1'b1) : fb_reg[0];
        d_top   = {d_abs, {QUO_W{1'b0}}};
        ovf_now = ({{DIV_W{1'b0}}, acc_abs} >= {{ACC_W{1'b0}}, d_top});
    end

    // sign, saturation and fault handling of the quotient
    always_comb begin
        y_val   = q_reg;
        sat_val = 1'b0;
        if (fault_reg) begin
            y_val = '0;
        end else if (ovf_reg) begin
            sat_val = 1'b1;
            y_val   = neg_reg ? iir_pkg::NEG_LIMIT : iir_pkg::POS_LIMIT;
        end else if (neg_reg) begin
            if (q_reg > iir_pkg::NEG_LIMIT) begin
                sat_val = 1'b1;
                y_val   = iir_pkg::NEG_LIMIT;
            end else begin
                y_val = ~q_reg + 1'b1;
            end
        end else if (q_reg > iir_pkg::POS_LIMIT) begin
            sat_val = 1'b1;
            y_val   = iir_pkg::POS_LIMIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                fwd_reg[i] <= '0;
                fb_reg[i]  <= '0;
            end
            fill_reg     <= '0;
            prod_vld_reg <= 1'b0;
        end else begin
            for (int i = 0; i < TAPS; i++) begin
                if (cmd.load_b && (32'(s_data.coef_index) == i)) begin
                    fwd_reg[i] <= s_data.coef_value;
                end
                if (cmd.load_a && (32'(s_data.coef_index) == i)) begin
                    fb_reg[i] <= s_data.coef_value;
                end
            end
            prod_vld_reg <= cmd.mac_issue;
            if (cmd.start && s_data.frame_start) begin
                fill_reg <= '0;
            end else if (cmd.finish && (fill_reg != TAP_W'(HIST_N))) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg   <= s_data.sample_in;
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_b_reg) - ACC_W'(prod_a_reg);
        end
        if (cmd.mac_issue) begin
            prod_b_reg <= prod_b_next;
            prod_a_reg <= prod_a_next;
        end
        if (cmd.check) begin
            rem_reg   <= acc_abs[DIV_W-1:0];
            dv_reg    <= DIV_W'({d_abs, {(QUO_W - 1){1'b0}}});
            q_reg     <= '0;
            neg_reg   <= acc_reg[ACC_W-1] ^ fb_reg[0][COEF_W-1];
            ovf_reg   <= ovf_now;
            fault_reg <= (fb_reg[0] == '0);
        end else if (cmd.div_step) begin
            if (rem_reg >= dv_reg) begin
                rem_reg <= rem_reg - dv_reg;
                q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[QUO_W-2:0], 1'b0};
            end
            dv_reg <= dv_reg >> 1;
        end
        if (cmd.finish) begin
            result_reg.sample_out   <= y_val;
            result_reg.saturated    <= sat_val;
            result_reg.divide_fault <= fault_reg;
            for (int i = HIST_N - 1; i > 0; i--) begin
                in_hist_reg[i]  <= in_hist_reg[i-1];
                out_hist_reg[i] <= out_hist_reg[i-1];
            end
            in_hist_reg[0]  <= x_reg;
            out_hist_reg[0] <= y_val;
        end
    end

endmodule

`default_nettype wire

### design/iir_direct_form_filter.sv
// top level of the direct-form i iir filter; joins iir_ctrl and iir_datapath
// depends on iir_pkg, iir_ctrl, iir_datapath
// sequence: an accepted sample walks the taps over two shared multipliers, drains the
// products, tests for divide overflow and fault, runs the 16-step restoring divider and
// waits for a free output; no new sample is taken meanwhile; coefficient loads stay idle
// reset: synchronous active low, clears coefficients, history depth and handshake state
`default_nettype none

module iir_direct_form_filter (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire iir_pkg::iir_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output iir_pkg::iir_out_t     m_data
);

    iir_pkg::iir_cmd_t cmd;

    iir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    iir_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
